>>> hw/rtl/cpu8080_alu_flag_unit_assert.svh
// Assertion macros shared by the ALU flag unit RTL.
// Each macro expects clk and rst_n to be visible at the point of use.
`ifndef CPU8080_ALU_FLAG_UNIT_ASSERT_SVH
`define CPU8080_ALU_FLAG_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CAFU_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CAFU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/cafu_pkg.sv
// Package for the 8080-style ALU flag unit.
// Holds the operation and condition codes and the flag bundle type; no dependencies.
`timescale 1ns / 1ps

package cafu_pkg;

    localparam int unsigned FUNC_W = 4;
    localparam int unsigned DATA_W = 16;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned COND_W = 3;
    localparam int unsigned SIGN_BIT = 7;

    typedef enum logic [FUNC_W-1:0] {
        FN_ADD8  = 4'd0,
        FN_ADC8  = 4'd1,
        FN_SUB8  = 4'd2,
        FN_SBB8  = 4'd3,
        FN_CMP8  = 4'd4,
        FN_RLC   = 4'd5,
        FN_RRC   = 4'd6,
        FN_RAL   = 4'd7,
        FN_RAR   = 4'd8,
        FN_ADD16 = 4'd9,
        FN_SUB16 = 4'd10,
        FN_SBB16 = 4'd11,
        FN_CMP16 = 4'd12,
        FN_COND  = 4'd13
    } func_t;

    typedef enum logic [COND_W-1:0] {
        CC_NZ = 3'd0,
        CC_Z  = 3'd1,
        CC_NC = 3'd2,
        CC_C  = 3'd3,
        CC_PO = 3'd4,
        CC_PE = 3'd5,
        CC_P  = 3'd6,
        CC_M  = 3'd7
    } cond_t;

    typedef struct packed {
        logic zero;
        logic sign;
        logic parity;
        logic carry;
    } flags_t;

endpackage

>>> hw/rtl/cafu_exec.sv
// Combinational execute logic of the ALU flag unit.
// Computes the result, the next flags and the condition bit; uses cafu_pkg.
`timescale 1ns / 1ps

module cafu_exec
    import cafu_pkg::*;
(
    input  logic [FUNC_W-1:0] func,
    input  logic [DATA_W-1:0] operand_a,
    input  logic [DATA_W-1:0] operand_b,
    input  logic [COND_W-1:0] cond_code,
    input  flags_t            flags_cur,
    output logic [DATA_W-1:0] result,
    output flags_t            flags_new,
    output logic              condition_met
);

    logic [BYTE_W-1:0] a8;
    logic [BYTE_W-1:0] b8;
    logic              cin;
    logic [BYTE_W:0]   sum8;
    logic [BYTE_W:0]   diff8;
    logic [DATA_W:0]   sum16;
    logic [DATA_W:0]   diff16;
    logic [BYTE_W-1:0] byte_res;
    logic              use_zsp;

    assign a8 = operand_a[BYTE_W-1:0];
    assign b8 = operand_b[BYTE_W-1:0];

    always_comb
    begin
        cin = 1'b0;
        if (func_t'(func) == FN_ADC8 || func_t'(func) == FN_SBB8 ||
            func_t'(func) == FN_SBB16)
        begin
            cin = flags_cur.carry;
        end
    end

    // The top bit of each difference is the borrow out.
    assign sum8   = {1'b0, a8} + {1'b0, b8} + {{BYTE_W{1'b0}}, cin};
    assign diff8  = {1'b0, a8} - {1'b0, b8} - {{BYTE_W{1'b0}}, cin};
    assign sum16  = {1'b0, operand_a} + {1'b0, operand_b};
    assign diff16 = {1'b0, operand_a} - {1'b0, operand_b} - {{DATA_W{1'b0}}, cin};

    always_comb
    begin
        result        = '0;
        flags_new     = flags_cur;
        condition_met = 1'b0;
        byte_res      = '0;
        use_zsp       = 1'b0;
        case (func_t'(func))
            FN_ADD8, FN_ADC8:
            begin
                byte_res        = sum8[BYTE_W-1:0];
                result          = {{(DATA_W-BYTE_W){1'b0}}, byte_res};
                flags_new.carry = sum8[BYTE_W];
                use_zsp         = 1'b1;
            end
            FN_SUB8, FN_SBB8, FN_CMP8:
            begin
                byte_res        = diff8[BYTE_W-1:0];
                if (func_t'(func) != FN_CMP8)
                begin
                    result = {{(DATA_W-BYTE_W){1'b0}}, byte_res};
                end
                flags_new.carry = diff8[BYTE_W];
                use_zsp         = 1'b1;
            end
            FN_RLC:
            begin
                result          = {{(DATA_W-BYTE_W){1'b0}}, a8[BYTE_W-2:0], a8[BYTE_W-1]};
                flags_new.carry = a8[BYTE_W-1];
            end
            FN_RRC:
            begin
                result          = {{(DATA_W-BYTE_W){1'b0}}, a8[0], a8[BYTE_W-1:1]};
                flags_new.carry = a8[0];
            end
            FN_RAL:
            begin
                result          = {{(DATA_W-BYTE_W){1'b0}}, a8[BYTE_W-2:0], flags_cur.carry};
                flags_new.carry = a8[BYTE_W-1];
            end
            FN_RAR:
            begin
                result          = {{(DATA_W-BYTE_W){1'b0}}, flags_cur.carry, a8[BYTE_W-1:1]};
                flags_new.carry = a8[0];
            end
            FN_ADD16:
            begin
                result          = sum16[DATA_W-1:0];
                flags_new.carry = sum16[DATA_W];
            end
            FN_SUB16, FN_SBB16:
            begin
                result          = diff16[DATA_W-1:0];
                flags_new.carry = diff16[DATA_W];
            end
            FN_CMP16:
            begin
                flags_new.zero  = (operand_a == operand_b);
                flags_new.carry = diff16[DATA_W];
            end
            FN_COND:
            begin
                case (cond_t'(cond_code))
                    CC_NZ:   condition_met = !flags_cur.zero;
                    CC_Z:    condition_met = flags_cur.zero;
                    CC_NC:   condition_met = !flags_cur.carry;
                    CC_C:    condition_met = flags_cur.carry;
                    CC_PO:   condition_met = !flags_cur.parity;
                    CC_PE:   condition_met = flags_cur.parity;
                    CC_P:    condition_met = !flags_cur.sign;
                    CC_M:    condition_met = flags_cur.sign;
                    default: condition_met = 1'b0;
                endcase
            end
            default:
            begin
                result = '0;
            end
        endcase

        if (use_zsp)
        begin
            flags_new.zero   = (byte_res == '0);
            flags_new.sign   = byte_res[SIGN_BIT];
            flags_new.parity = ~^byte_res;
        end
    end

endmodule

>>> hw/rtl/cpu8080_alu_flag_unit.sv
// Usage notes for the 8080-style ALU and flag unit.
// The input channel carries one request per item: func, operand_a, operand_b and
// cond_code, qualified by in_valid and held off by in_stall. The output channel
// returns one request per item: result, the four flags after the item and
// condition_met, qualified by out_valid and held off by out_stall.
// Each accepted request sits in an input register, passes through one level of
// execute logic and lands in a result register that drives the outputs. One
// request is accepted every cycle while the receiver takes results; the flag
// register is the only feedback between items and is updated in the cycle the
// item moves into the result register.
// When the receiver stalls, the result register holds its request and the input
// register keeps the next one, so in_stall rises only once both are full.
// Reset clears both valid bits and the zero, sign, parity and carry flags.
// This file depends on cafu_pkg, cafu_exec and the assertion macro header.
`timescale 1ns / 1ps
`include "cpu8080_alu_flag_unit_assert.svh"

module cpu8080_alu_flag_unit
    import cafu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [FUNC_W-1:0] func,
    input  logic [DATA_W-1:0] operand_a,
    input  logic [DATA_W-1:0] operand_b,
    input  logic [COND_W-1:0] cond_code,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [DATA_W-1:0] result,
    output logic              zero_flag,
    output logic              sign_flag,
    output logic              parity_flag,
    output logic              carry_flag,
    output logic              condition_met
);

    logic              in_valid_reg;
    logic [FUNC_W-1:0] func_reg;
    logic [DATA_W-1:0] operand_a_reg;
    logic [DATA_W-1:0] operand_b_reg;
    logic [COND_W-1:0] cond_code_reg;

    flags_t            flags_reg;
    flags_t            flags_next;
    logic [DATA_W-1:0] result_next;
    logic              met_next;

    logic              out_valid_reg;
    logic [DATA_W-1:0] result_reg;
    flags_t            out_flags_reg;
    logic              met_reg;

    logic              out_free;
    logic              advance;
    logic              in_take;
    logic              cond_advance;

    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;
    assign cond_advance = advance && (func_t'(func_reg) == FN_COND);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            func_reg      <= func;
            operand_a_reg <= operand_a;
            operand_b_reg <= operand_b;
            cond_code_reg <= cond_code;
        end
    end

    cafu_exec u_exec (
        .func          (func_reg),
        .operand_a     (operand_a_reg),
        .operand_b     (operand_b_reg),
        .cond_code     (cond_code_reg),
        .flags_cur     (flags_reg),
        .result        (result_next),
        .flags_new     (flags_next),
        .condition_met (met_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                flags_reg <= flags_next;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg    <= result_next;
            out_flags_reg <= flags_next;
            met_reg       <= met_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign result        = result_reg;
    assign zero_flag     = out_flags_reg.zero;
    assign sign_flag     = out_flags_reg.sign;
    assign parity_flag   = out_flags_reg.parity;
    assign carry_flag    = out_flags_reg.carry;
    assign condition_met = met_reg;

    `CAFU_ASSERT_NEXT(a_flags_hold, !advance, $stable(flags_reg), "flags changed without an item")
    `CAFU_ASSERT_NEXT(a_flags_shown, advance, out_flags_reg == flags_reg, "shown flags differ")
    `CAFU_ASSERT_NEXT(a_cond_keeps, cond_advance, $stable(flags_reg), "condition test changed flags")
    `CAFU_ASSERT_SAME(a_met_no_result, out_valid_reg && met_reg, result_reg == '0, "met with result")

endmodule
